// File: sv/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared constants and types of the circular byte buffer: store geometry,
// field widths, the queued item and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

	// Store geometry and burst limit
	localparam int STORE_DEPTH    = 1024;
	localparam int MAX_READ_BURST = 64;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);

	// Field widths
	localparam int CNT_W   = 11;
	localparam int BURST_W = 7;
	localparam int BYTE_W  = 8;

	// Operation codes of the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// One classified item waiting for the back end
	typedef struct packed {
		logic               is_read;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic [BURST_W-1:0] count;
	} item_t;

	// Head of the item queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// One result record, without the data byte
	typedef struct packed {
		logic             is_read;
		logic             valid;
		logic [CNT_W-1:0] moved;
		logic             last;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] free;
	} result_t;

endpackage

`default_nettype wire

// File: sv/cbb_front.sv
// ----------------------------------------------------------------------------
// cbb_front
// Accepts items, classifies them (write or read, read length clamped to the
// burst limit) and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_front
	import cbb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               func,
	input  wire logic [BYTE_W-1:0]  write_byte,
	input  wire logic               write_last,
	input  wire logic [BURST_W-1:0] read_count,
	output queue_head_t             head,
	input  wire logic               pop
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item_in;

	// Classify the incoming item
	always_comb begin
		item_in.is_read = (func == FUNC_READ);
		item_in.data    = write_byte;
		item_in.last    = write_last;
		if (read_count > BURST_W'(MAX_READ_BURST))
			item_in.count = BURST_W'(MAX_READ_BURST);
		else
			item_in.count = read_count;
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	// Store the entry
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= item_in;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: sv/cbb_back.sv
// ----------------------------------------------------------------------------
// cbb_back
// Carries out queued items against the ring store: stores write bytes and
// counts them per request, streams read bursts one byte per cycle.
// Holds the capacity register; a capacity write flushes the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_back
	import cbb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             capacity_we,
	input  wire logic [CNT_W-1:0] capacity,
	input  queue_head_t           head,
	output logic                  pop,
	output logic                  strobe,
	output result_t               res,
	output logic [BYTE_W-1:0]     rd_byte
);

	localparam int PW = CNT_W + 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic [BYTE_W-1:0]  mem [STORE_DEPTH];
	logic [BYTE_W-1:0]  rdata_q;
	logic [CNT_W-1:0]   cap_q;
	logic [ADDR_W-1:0]  rp_q;
	logic [CNT_W-1:0]   sc_q;
	logic [CNT_W-1:0]   wbc_q;
	logic               state_q;
	logic [ADDR_W-1:0]  rd_ptr_q;
	logic [BURST_W-1:0] rem_q;
	logic [BURST_W-1:0] amt_q;
	logic               strobe_s1;
	result_t            res_s1;

	logic [CNT_W-1:0]   ecap;
	logic [PW-1:0]      wsum;
	logic [PW-1:0]      wpos;
	logic               has_room;
	logic               mem_we;
	logic [CNT_W-1:0]   sc_w;
	logic [CNT_W-1:0]   wbc_inc;
	logic [BURST_W-1:0] amount;
	logic [PW-1:0]      rsum;
	logic [PW-1:0]      rp_next;
	logic [PW-1:0]      nptr;
	logic               res_load;
	result_t            res_d;
	logic               is_wr;
	logic               is_rd;

	// Effective capacity and ring arithmetic
	always_comb begin
		if (cap_q == '0)
			ecap = CNT_W'(1);
		else if (cap_q > CNT_W'(STORE_DEPTH))
			ecap = CNT_W'(STORE_DEPTH);
		else
			ecap = cap_q;

		has_room = (sc_q < ecap);
		wsum     = PW'(rp_q) + PW'(sc_q);
		wpos     = (wsum >= PW'(ecap)) ? wsum - PW'(ecap) : wsum;
		sc_w     = has_room ? sc_q + CNT_W'(1) : sc_q;
		if (has_room && (wbc_q != {CNT_W{1'b1}}))
			wbc_inc = wbc_q + CNT_W'(1);
		else
			wbc_inc = wbc_q;

		if (PW'(head.item.count) > PW'(sc_q))
			amount = sc_q[BURST_W-1:0];
		else
			amount = head.item.count;
		rsum    = PW'(rp_q) + PW'(amount);
		rp_next = (rsum >= PW'(ecap)) ? rsum - PW'(ecap) : rsum;

		nptr = PW'(rd_ptr_q) + PW'(1);
		if (nptr == PW'(ecap))
			nptr = '0;
	end

	assign pop    = head.valid && (state_q == ST_IDLE) && !capacity_we;
	assign is_wr  = pop && !head.item.is_read;
	assign is_rd  = pop && head.item.is_read;
	assign mem_we = is_wr && has_room;

	// Build the next result record
	always_comb begin
		res_load      = 1'b0;
		res_d.is_read = 1'b1;
		res_d.valid   = 1'b0;
		res_d.moved   = '0;
		res_d.last    = 1'b1;
		res_d.fill    = sc_q;
		res_d.free    = ecap - sc_q;
		if (state_q == ST_READ) begin
			res_load    = 1'b1;
			res_d.valid = 1'b1;
			res_d.moved = CNT_W'(amt_q);
			res_d.last  = (rem_q == BURST_W'(1));
		end else if (is_wr && head.item.last) begin
			res_load      = 1'b1;
			res_d.is_read = 1'b0;
			res_d.moved   = wbc_inc;
			res_d.fill    = sc_w;
			res_d.free    = ecap - sc_w;
		end else if (is_rd && (amount == '0)) begin
			res_load = 1'b1;
		end
	end

	// Store write bytes, fetch read bytes
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wpos[ADDR_W-1:0]] <= head.item.data;
		rdata_q <= mem[rd_ptr_q];
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (res_load)
			res_s1 <= res_d;
	end

	// Ring state, capacity and read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CNT_W'(STORE_DEPTH);
			rp_q      <= '0;
			sc_q      <= '0;
			wbc_q     <= '0;
			state_q   <= ST_IDLE;
			rd_ptr_q  <= '0;
			rem_q     <= '0;
			amt_q     <= '0;
			strobe_s1 <= 1'b0;
		end else if (capacity_we) begin
			cap_q     <= capacity;
			rp_q      <= '0;
			sc_q      <= '0;
			wbc_q     <= '0;
			state_q   <= ST_IDLE;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= res_load;
			case (state_q)
				ST_IDLE: begin
					if (is_wr) begin
						sc_q  <= sc_w;
						wbc_q <= head.item.last ? '0 : wbc_inc;
					end else if (is_rd && (amount != '0)) begin
						rd_ptr_q <= rp_q;
						rp_q     <= rp_next[ADDR_W-1:0];
						sc_q     <= sc_q - CNT_W'(amount);
						rem_q    <= amount;
						amt_q    <= amount;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_ptr_q <= nptr[ADDR_W-1:0];
					rem_q    <= rem_q - BURST_W'(1);
					if (rem_q == BURST_W'(1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe  = strobe_s1;
	assign res     = res_s1;
	assign rd_byte = res_s1.valid ? rdata_q : '0;

endmodule

`default_nettype wire

// File: sv/circular_byte_buffer_core.sv
// ----------------------------------------------------------------------------
// circular_byte_buffer_core
// Byte ring buffer with a run-time capacity: per-byte writes with a request
// count on the last byte, and read bursts of up to 64 bytes.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------
//   config    capacity_we          capacity
//   input     start && !busy       func, write_byte, write_last, read_count
//   result    strobe (one cycle)   is_read, read_byte, byte_valid,
//                                  moved_count, last, fill_level,
//                                  free_space, empty_res
//
// A write byte is stored as the back end pops it; writes stream at one per
// cycle while no read burst runs. A read is set up, then delivers one byte
// per cycle from the single store read port; an empty read gives one
// byteless result. An accepted item passes the item queue register and the
// result register before its result appears. busy rises when the two-entry
// item queue is full. Results cannot be held off. Reset (arst_n low)
// empties the ring and sets capacity to 1024; capacity writes flush the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_byte_buffer_core
	import cbb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               capacity_we,
	input  wire logic [CNT_W-1:0]   capacity,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               func,
	input  wire logic [BYTE_W-1:0]  write_byte,
	input  wire logic               write_last,
	input  wire logic [BURST_W-1:0] read_count,
	output logic                    strobe,
	output logic                    is_read,
	output logic [BYTE_W-1:0]       read_byte,
	output logic                    byte_valid,
	output logic [CNT_W-1:0]        moved_count,
	output logic                    last,
	output logic [CNT_W-1:0]        fill_level,
	output logic [CNT_W-1:0]        free_space,
	output logic                    empty_res
);

	queue_head_t head;
	logic        pop;
	result_t     res;

	// Accept and queue items
	cbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.write_byte (write_byte),
		.write_last (write_last),
		.read_count (read_count),
		.head       (head),
		.pop        (pop)
	);

	// Execute against the ring store
	cbb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity_we (capacity_we),
		.capacity    (capacity),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.res         (res),
		.rd_byte     (read_byte)
	);

	// Unpack the result record
	assign is_read     = res.is_read;
	assign byte_valid  = res.valid;
	assign moved_count = res.moved;
	assign last        = res.last;
	assign fill_level  = res.fill;
	assign free_space  = res.free;
	assign empty_res   = (res.fill == '0);

endmodule

`default_nettype wire

// File: sv/cbb_checker.sv
// ----------------------------------------------------------------------------
// cbb_checker
// Port-level checks on the result stream of the circular byte buffer,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_checker
	import cbb_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              strobe,
	input wire logic              is_read,
	input wire logic              byte_valid,
	input wire logic [CNT_W-1:0]  moved_count,
	input wire logic              last,
	input wire logic [CNT_W-1:0]  fill_level
);

	// Write completions and empty reads are single, byteless results
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !byte_valid |-> last)
		else $error("byteless result without last");

	// An empty read reports nothing moved
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_read && !byte_valid |-> (moved_count == '0))
		else $error("empty read with nonzero count");

	// A read burst continues on the next cycle until its last byte
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && byte_valid && !last |=> strobe && is_read && byte_valid)
		else $error("read burst broken");

	// Burst count and fill level hold across one burst
	a_burst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && byte_valid && !last |=>
			(moved_count == $past(moved_count)) && (fill_level == $past(fill_level)))
		else $error("burst fields changed within a burst");

endmodule

bind circular_byte_buffer_core cbb_checker u_cbb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.strobe      (strobe),
	.is_read     (is_read),
	.byte_valid  (byte_valid),
	.moved_count (moved_count),
	.last        (last),
	.fill_level  (fill_level)
);

`default_nettype wire
